// ----- design/road_turn_transition_cost_macros.svh -----
// Assertion macros for the road turn transition cost block.
// Used by the RTL files under design; expects clk_i and rst_ni in scope.
`ifndef ROAD_TURN_TRANSITION_COST_MACROS_SVH
`define ROAD_TURN_TRANSITION_COST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RTTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RTTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rttc_pkg.sv -----
// Package for the road turn transition cost block: item types, codes,
// register indexes and the density and turn cost tables. No dependencies.
`default_nettype none

package rttc_pkg;

  localparam int unsigned FieldW   = 20;  // one time or penalty field
  localparam int unsigned PairW    = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DensW    = 6;   // density factor in tenths
  localparam int unsigned TurnQW   = 5;   // turn cost in quarters
  localparam int unsigned DtW      = 11;  // density * turn
  localparam int unsigned ProdW    = 13;  // density * impact * turn, max 4900
  localparam int unsigned TurnW    = 11;  // turn time, max 1960
  localparam int unsigned TimeW    = 23;
  localparam int unsigned TotalW   = 24;

  localparam logic [ProdW-1:0]  ProdMax     = 13'd4900;
  localparam logic [TurnQW-1:0] CrossingQ   = 5'd8;
  // floor(x / 5) = (x * 52429) >> 18 for every x below 2^14
  localparam logic [16:0]       DivFiveRecip = 17'd52429;
  localparam int unsigned       DivFiveShift = 18;

  localparam logic [PairW-1:0]  BorderRst = 40'd9600;
  localparam logic [PairW-1:0]  GateRst   = 40'd5033165280;
  localparam logic [PairW-1:0]  TollRst   = 40'd240;
  localparam logic [PairW-1:0]  FerryRst  = 40'd4800;
  localparam logic [FieldW-1:0] DestRst   = 20'd9600;
  localparam logic [FieldW-1:0] AlleyRst  = 20'd480;
  localparam logic [FieldW-1:0] NameRst   = 20'd80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BORDER = 3'd0,
    CFG_GATE   = 3'd1,
    CFG_TOLL   = 3'd2,
    CFG_FERRY  = 3'd3,
    CFG_DEST   = 3'd4,
    CFG_ALLEY  = 3'd5,
    CFG_NAME   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    NODE_ORDINARY = 2'd0,
    NODE_BORDER   = 2'd1,
    NODE_GATE     = 2'd2,
    NODE_TOLL     = 2'd3
  } node_type_e;

  typedef enum logic [1:0] {
    USE_OTHER = 2'd0,
    USE_ALLEY = 2'd1,
    USE_BOAT  = 2'd2
  } edge_use_e;

  localparam int unsigned FlagToll = 0;
  localparam int unsigned FlagDest = 1;

  typedef struct packed {
    logic [1:0] node_type;
    logic [3:0] node_density;
    logic [1:0] prev_flags;
    logic [1:0] prev_use;
    logic [1:0] next_flags;
    logic [1:0] next_use;
    logic       names_consistent;
    logic [2:0] stop_impact;
    logic [2:0] turn_kind;
    logic       edge_on_right;
    logic       edge_on_left;
    logic       drives_on_right;
  } rttc_in_t;

  typedef struct packed {
    logic [TotalW-1:0] total_cost;
    logic [TimeW-1:0]  time_cost;
  } rttc_out_t;

  // Turn geometry handed to the turn time pipeline.
  typedef struct packed {
    logic [3:0] node_density;
    logic [2:0] stop_impact;
    logic [2:0] turn_kind;
    logic       edge_on_right;
    logic       edge_on_left;
    logic       drives_on_right;
  } rttc_turn_t;

  function automatic logic [DensW-1:0] density_tenths(input logic [3:0] idx);
    logic [DensW-1:0] f;
    case (idx)
      4'd5:    f = 6'd11;
      4'd6:    f = 6'd12;
      4'd7:    f = 6'd13;
      4'd8:    f = 6'd14;
      4'd9:    f = 6'd16;
      4'd10:   f = 6'd19;
      4'd11:   f = 6'd22;
      4'd12:   f = 6'd25;
      4'd13:   f = 6'd28;
      4'd14:   f = 6'd31;
      4'd15:   f = 6'd35;
      default: f = 6'd10;
    endcase
    return f;
  endfunction

  function automatic logic [TurnQW-1:0] right_turn_q(input logic [2:0] kind);
    logic [TurnQW-1:0] q;
    case (kind)
      3'd0:    q = 5'd2;
      3'd1:    q = 5'd3;
      3'd2:    q = 5'd4;
      3'd3:    q = 5'd6;
      3'd4:    q = 5'd20;
      3'd5:    q = 5'd14;
      3'd6:    q = 5'd10;
      default: q = 5'd3;
    endcase
    return q;
  endfunction

  function automatic logic [TurnQW-1:0] left_turn_q(input logic [2:0] kind);
    logic [TurnQW-1:0] q;
    case (kind)
      3'd0:    q = 5'd2;
      3'd1:    q = 5'd3;
      3'd2:    q = 5'd10;
      3'd3:    q = 5'd14;
      3'd4:    q = 5'd20;
      3'd5:    q = 5'd6;
      3'd6:    q = 5'd4;
      default: q = 5'd3;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- design/rttc_turn.sv -----
// Turn time pipeline: density * stop impact * turn cost, scaled to 1/16 s.
// Three register stages; depends on rttc_pkg and the assertion macros.
`default_nettype none

`include "road_turn_transition_cost_macros.svh"

module rttc_turn
  import rttc_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  rttc_turn_t      turn_i,
  output logic [TurnW-1:0] turn_time_o
);

  logic [TurnQW-1:0] turn_q_sel;
  logic [DtW-1:0]    dt_d, dt_q;
  logic [2:0]        imp_q;
  logic [ProdW-1:0]  p_d, p_q;
  logic [ProdW:0]    x2;
  logic [30:0]       recip_prod;
  logic [TurnW-1:0]  q_d, q_q;

  always_comb begin
    if (turn_i.edge_on_right && turn_i.edge_on_left) begin
      turn_q_sel = CrossingQ;
    end else if (turn_i.drives_on_right) begin
      turn_q_sel = right_turn_q(turn_i.turn_kind);
    end else begin
      turn_q_sel = left_turn_q(turn_i.turn_kind);
    end
  end

  assign dt_d       = DtW'(density_tenths(turn_i.node_density)) * DtW'(turn_q_sel);
  assign p_d        = ProdW'(dt_q) * ProdW'(imp_q);
  // round to nearest: floor((2p + 2) / 5)
  assign x2         = {p_q, 1'b0} + (ProdW+1)'(2);
  assign recip_prod = 31'(x2) * 31'(DivFiveRecip);
  assign q_d        = recip_prod[DivFiveShift +: TurnW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= '0;
      imp_q <= '0;
      p_q   <= '0;
      q_q   <= '0;
    end else begin
      dt_q  <= dt_d;
      imp_q <= turn_i.stop_impact;
      p_q   <= p_d;
      q_q   <= q_d;
    end
  end

  assign turn_time_o = q_q;

  `RTTC_ASSERT_NXT(a_no_impact_no_prod, imp_q == 3'd0, p_q == '0, "turn product without impact")
  `RTTC_ASSERT_IMP(a_prod_bound, 1'b1, p_q <= ProdMax, "turn product out of range")
  `RTTC_ASSERT_NXT(a_zero_prod_rounds, p_q == '0, q_q == '0, "zero product gave turn time")

endmodule

`default_nettype wire

// ----- design/road_turn_transition_cost.sv -----
// Road turn transition cost: one item per cycle, result strobed on done_o
// after stages 1 to 3 and the output stage. Nothing stalls, so busy_o stays
// low and a new item may start every cycle. The pipeline depth is set by the
// turn time path (two multiplies and a reciprocal divide, one per stage).
// Reset clears the valid pipeline and loads the default costs and penalties.
`default_nettype none

`include "road_turn_transition_cost_macros.svh"

module road_turn_transition_cost
  import rttc_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  rttc_in_t           item_i,
  output logic               busy_o,
  output logic               done_o,
  output rttc_out_t          result_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire [CfgIdxW-1:0]  cfg_index_i,
  input  wire [PairW-1:0]    cfg_data_i
);

  // configuration registers
  logic [PairW-1:0]  border_q, gate_q, toll_q, ferry_q;
  logic [FieldW-1:0] dest_q, alley_q, name_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= BorderRst;
      gate_q   <= GateRst;
      toll_q   <= TollRst;
      ferry_q  <= FerryRst;
      dest_q   <= DestRst;
      alley_q  <= AlleyRst;
      name_q   <= NameRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BORDER: border_q <= cfg_data_i;
        CFG_GATE:   gate_q   <= cfg_data_i;
        CFG_TOLL:   toll_q   <= cfg_data_i;
        CFG_FERRY:  ferry_q  <= cfg_data_i;
        CFG_DEST:   dest_q   <= cfg_data_i[FieldW-1:0];
        CFG_ALLEY:  alley_q  <= cfg_data_i[FieldW-1:0];
        CFG_NAME:   name_q   <= cfg_data_i[FieldW-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 1: pick the terms that apply
  logic [PairW-1:0]  node_pair, toll_pair, ferry_pair;
  logic [FieldW-1:0] dest_pen, alley_pen, name_pen;
  logic              toll_hit, ferry_hit;

  always_comb begin
    case (node_type_e'(item_i.node_type))
      NODE_BORDER: node_pair = border_q;
      NODE_GATE:   node_pair = gate_q;
      default:     node_pair = '0;
    endcase
    toll_hit  = (item_i.node_type == NODE_TOLL)
             || (!item_i.prev_flags[FlagToll] && item_i.next_flags[FlagToll]);
    ferry_hit = (item_i.prev_use != USE_BOAT) && (item_i.next_use == USE_BOAT);
    toll_pair  = toll_hit ? toll_q : '0;
    ferry_pair = ferry_hit ? ferry_q : '0;
    dest_pen   = (!item_i.prev_flags[FlagDest] && item_i.next_flags[FlagDest])
               ? dest_q : '0;
    alley_pen  = ((item_i.prev_use != USE_ALLEY) && (item_i.next_use == USE_ALLEY))
               ? alley_q : '0;
    name_pen   = item_i.names_consistent ? '0 : name_q;
  end

  logic              s1_valid_q;
  logic [PairW-1:0]  s1_node_q, s1_toll_q, s1_ferry_q;
  logic [FieldW-1:0] s1_dest_q, s1_alley_q, s1_name_q;

  // stage 2: partial sums
  logic              s2_valid_q;
  logic [FieldW+1:0] s2_time_q, s2_pen_a_q, s2_pen_b_q;
  logic [FieldW+1:0] s2_time_d, s2_pen_a_d, s2_pen_b_d;

  assign s2_time_d  = (FieldW+2)'(s1_node_q[FieldW-1:0])
                    + (FieldW+2)'(s1_toll_q[FieldW-1:0])
                    + (FieldW+2)'(s1_ferry_q[FieldW-1:0]);
  assign s2_pen_a_d = (FieldW+2)'(s1_node_q[PairW-1:FieldW])
                    + (FieldW+2)'(s1_toll_q[PairW-1:FieldW])
                    + (FieldW+2)'(s1_ferry_q[PairW-1:FieldW]);
  assign s2_pen_b_d = (FieldW+2)'(s1_dest_q) + (FieldW+2)'(s1_alley_q)
                    + (FieldW+2)'(s1_name_q);

  // stage 3: time plus penalties, turn time still to come
  logic              s3_valid_q;
  logic [FieldW+1:0] s3_time_q;
  logic [TotalW-1:0] s3_sum_q, s3_sum_d;

  assign s3_sum_d = TotalW'(s2_time_q) + TotalW'(s2_pen_a_q) + TotalW'(s2_pen_b_q);

  // turn time lands alongside stage 3
  rttc_turn_t      turn_geo;
  logic [TurnW-1:0] turn_time;

  assign turn_geo = '{
    node_density:    item_i.node_density,
    stop_impact:     item_i.stop_impact,
    turn_kind:       item_i.turn_kind,
    edge_on_right:   item_i.edge_on_right,
    edge_on_left:    item_i.edge_on_left,
    drives_on_right: item_i.drives_on_right
  };

  rttc_turn u_turn (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .turn_i      (turn_geo),
    .turn_time_o (turn_time)
  );

  // output stage
  logic      out_valid_q;
  rttc_out_t out_q, out_d;

  assign out_d.time_cost  = TimeW'(s3_time_q) + TimeW'(turn_time);
  assign out_d.total_cost = s3_sum_q + TotalW'(turn_time);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_node_q  <= node_pair;
    s1_toll_q  <= toll_pair;
    s1_ferry_q <= ferry_pair;
    s1_dest_q  <= dest_pen;
    s1_alley_q <= alley_pen;
    s1_name_q  <= name_pen;
    s2_time_q  <= s2_time_d;
    s2_pen_a_q <= s2_pen_a_d;
    s2_pen_b_q <= s2_pen_b_d;
    s3_time_q  <= s2_time_q;
    s3_sum_q   <= s3_sum_d;
    out_q      <= out_d;
  end

  assign done_o   = out_valid_q;
  assign result_o = out_q;

  `RTTC_ASSERT_IMP(a_latency, $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4), done_o == $past(accept, 4), "done strobe out of step with accepted item")
  `RTTC_ASSERT_IMP(a_total_covers_time, done_o, result_o.total_cost >= TotalW'(result_o.time_cost), "total below time")
  `RTTC_ASSERT_IMP(a_sum_covers_time, s3_valid_q, s3_sum_q >= TotalW'(s3_time_q), "partial sum below time")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for road_turn_transition_cost: directed table, then random items.
// Depends on rttc_pkg and the block's RTL; takes each cost from the table, or predicts
// it from a local copy of the registers, and checks every strobed result in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rttc_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned ItemsPerPhase = 290;
  localparam int unsigned NumPhases = 5;
  localparam int unsigned NumRows = 25;
  localparam logic [1:0] USE_SPARE = 2'd3;  // no meaning, acts as other use

  localparam logic [5:0] DENS_TENTHS [16] = '{6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd16, 6'd19, 6'd22, 6'd25, 6'd28, 6'd31, 6'd35};
  localparam logic [4:0] RIGHT_SIDE_Q [8] = '{5'd2, 5'd3, 5'd4, 5'd6, 5'd20, 5'd14, 5'd10,
    5'd3};
  localparam logic [4:0] LEFT_SIDE_Q [8] = '{5'd2, 5'd3, 5'd10, 5'd14, 5'd20, 5'd6, 5'd4,
    5'd3};
  localparam logic [4:0] CROSS_Q = 5'd8;

  typedef enum logic [1:0] {FILL_MAX, FILL_ZERO, FILL_RAND} fill_e;

  typedef struct packed {
    rttc_in_t  item;
    logic      known;
    rttc_out_t cost;
  } cost_row_t;

  // item fields: node, density, prev flags, prev use, next flags, next use, names ok,
  // impact, turn kind, edge right, edge left, drives right
  localparam cost_row_t COST_ROWS [NumRows] = '{
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd0, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b0, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd80, 23'd0}},
    '{'{NODE_BORDER, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd9600, 23'd9600}},
    '{'{NODE_GATE, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd5280, 23'd480}},
    '{'{NODE_TOLL, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd240, 23'd240}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_OTHER, 2'b01, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd240, 23'd240}},
    '{'{NODE_ORDINARY, 4'd0, 2'b01, USE_OTHER, 2'b01, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd0, 23'd0}},
    // toll booth onto a toll road: charged once
    '{'{NODE_TOLL, 4'd0, 2'b00, USE_OTHER, 2'b01, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd240, 23'd240}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_OTHER, 2'b10, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd9600, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b10, USE_OTHER, 2'b10, USE_OTHER, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd0, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_ALLEY, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd480, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_ALLEY, 2'b00, USE_ALLEY, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd0, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_BOAT, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd4800, 23'd4800}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_BOAT, 2'b00, USE_BOAT, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd0, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_SPARE, 2'b00, USE_SPARE, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd0, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_SPARE, 2'b00, USE_ALLEY, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd480, 23'd0}},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_SPARE, 2'b00, USE_BOAT, 1'b1, 3'd0, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b1, '{24'd4800, 23'd4800}},
    // crossing: edges on both sides override turn kind and side
    '{'{NODE_ORDINARY, 4'd15, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd7, 3'd4,
        1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{NODE_ORDINARY, 4'd15, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd7, 3'd4,
        1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{NODE_ORDINARY, 4'd0, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd1, 3'd0,
        1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{NODE_ORDINARY, 4'd9, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd3, 3'd2,
        1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{NODE_ORDINARY, 4'd9, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd3, 3'd2,
        1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{NODE_GATE, 4'd12, 2'b00, USE_OTHER, 2'b00, USE_OTHER, 1'b1, 3'd5, 3'd5,
        1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{NODE_TOLL, 4'd15, 2'b11, USE_SPARE, 2'b11, USE_SPARE, 1'b0, 3'd7, 3'd7,
        1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{NODE_BORDER, 4'd10, 2'b00, USE_OTHER, 2'b11, USE_BOAT, 1'b0, 3'd4, 3'd3,
        1'b0, 1'b1, 1'b1}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  rttc_in_t item_i;
  logic busy_o;
  logic done_o;
  rttc_out_t result_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PairW-1:0] cfg_data_i;

  // typed expectation travels with the item it belongs to
  logic row_known;
  rttc_out_t row_cost;

  logic [PairW-1:0] border_pair, gate_pair, toll_pair, ferry_pair;
  logic [FieldW-1:0] dest_pen, alley_pen, name_pen;

  rttc_out_t costs_due [$];
  int unsigned cost_errors = 0;
  int unsigned quiet_cycles = 0;

  road_turn_transition_cost uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic rttc_out_t transition_cost(input rttc_in_t it);
    logic [63:0] tm;
    logic [63:0] pn;
    logic [63:0] prod;
    logic [4:0] quarters;
    rttc_out_t res;
    tm = '0;
    pn = '0;
    if (it.node_type == NODE_BORDER) begin
      tm = tm + 64'(border_pair[19:0]);
      pn = pn + 64'(border_pair[39:20]);
    end else if (it.node_type == NODE_GATE) begin
      tm = tm + 64'(gate_pair[19:0]);
      pn = pn + 64'(gate_pair[39:20]);
    end
    if (it.node_type == NODE_TOLL || (!it.prev_flags[FlagToll] && it.next_flags[FlagToll]))
    begin
      tm = tm + 64'(toll_pair[19:0]);
      pn = pn + 64'(toll_pair[39:20]);
    end
    if (!it.prev_flags[FlagDest] && it.next_flags[FlagDest]) pn = pn + 64'(dest_pen);
    if (it.prev_use != USE_ALLEY && it.next_use == USE_ALLEY) pn = pn + 64'(alley_pen);
    if (it.prev_use != USE_BOAT && it.next_use == USE_BOAT) begin
      tm = tm + 64'(ferry_pair[19:0]);
      pn = pn + 64'(ferry_pair[39:20]);
    end
    if (!it.names_consistent) pn = pn + 64'(name_pen);
    if (it.stop_impact != 3'd0) begin
      if (it.edge_on_right && it.edge_on_left) quarters = CROSS_Q;
      else if (it.drives_on_right) quarters = RIGHT_SIDE_Q[it.turn_kind];
      else quarters = LEFT_SIDE_Q[it.turn_kind];
      prod = 64'(DENS_TENTHS[it.node_density]) * 64'(it.stop_impact) * 64'(quarters);
      // tenths * quarters is 1/40 s; scale to 1/16 s, nearest
      tm = tm + (64'd2 * prod + 64'd2) / 64'd5;
    end
    res.total_cost = TotalW'(tm + pn);
    res.time_cost = TimeW'(tm);
    return res;
  endfunction

  always @(posedge clk_i) begin : watch_outputs
    rttc_out_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BORDER: border_pair = cfg_data_i;
          CFG_GATE:   gate_pair = cfg_data_i;
          CFG_TOLL:   toll_pair = cfg_data_i;
          CFG_FERRY:  ferry_pair = cfg_data_i;
          CFG_DEST:   dest_pen = cfg_data_i[FieldW-1:0];
          CFG_ALLEY:  alley_pen = cfg_data_i[FieldW-1:0];
          CFG_NAME:   name_pen = cfg_data_i[FieldW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) costs_due.push_back(row_known ? row_cost : transition_cost(item_i));
      if (done_o) begin
        if (costs_due.size() == 0) begin
          if (cost_errors < 10) $display("unexpected result total=%0d time=%0d",
                                         result_o.total_cost, result_o.time_cost);
          cost_errors++;
        end else begin
          want = costs_due.pop_front();
          if (result_o.total_cost !== want.total_cost ||
              result_o.time_cost !== want.time_cost) begin
            if (cost_errors < 10)
              $display("cost mismatch: total exp %0d got %0d, time exp %0d got %0d",
                       want.total_cost, result_o.total_cost, want.time_cost,
                       result_o.time_cost);
            cost_errors++;
          end
        end
      end
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Hold the item until the block takes it; leaves start high for a follow-on item.
  task automatic send_item(input rttc_in_t it, input int unsigned idle_pct, input logic known,
                           input rttc_out_t cost);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    row_known <= known;
    row_cost <= cost;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [PairW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop start, then wait out every result still in flight.
  task automatic drain_costs();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (costs_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    fill_e fills [NumPhases];
    int unsigned idles [NumPhases];
    logic [31:0] raw;
    logic [63:0] wide;
    rttc_in_t it;
    fills = '{FILL_MAX, FILL_ZERO, FILL_RAND, FILL_RAND, FILL_RAND};
    idles = '{0, 79, 19, 0, 79};
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    row_known = 1'b0;
    row_cost = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BORDER;
    cfg_data_i = '0;
    border_pair = 40'd9600;
    gate_pair = 40'd5033165280;
    toll_pair = 40'd240;
    ferry_pair = 40'd4800;
    dest_pen = 20'd9600;
    alley_pen = 20'd480;
    name_pen = 20'd80;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (COST_ROWS[r]) send_item(COST_ROWS[r].item, 0, COST_ROWS[r].known, COST_ROWS[r].cost);
    drain_costs();

    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int r = CFG_BORDER; r <= CFG_NAME; r++) begin
        wide = {$urandom, $urandom};
        case (fills[ph])
          FILL_MAX:  write_reg(cfg_idx_e'(r), '1);
          FILL_ZERO: write_reg(cfg_idx_e'(r), '0);
          default:   write_reg(cfg_idx_e'(r), wide[PairW-1:0]);
        endcase
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        raw = $urandom;
        it = raw[23:0];
        // push some items to the largest density and stop impact
        if ($urandom_range(7) == 0) begin
          it.node_density = 4'd15;
          it.stop_impact = 3'd7;
        end
        send_item(it, idles[ph], 1'b0, '0);
      end
      drain_costs();
    end

    if (cost_errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
